/* src/sbst_pkg.sv */
// Package for the symbol byte-stuff transmitter.
// Holds the byte codes, symbol kinds, sequencer states and escape unit result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbst_pkg;

	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
	localparam logic [7:0] ESCAPE_XOR  = 8'h20;

	localparam int KIND_W = 2;
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	// Payload byte counts per symbol kind
	localparam logic [2:0] CTRL_BYTES = 3'd3;
	localparam logic [2:0] DATA_BYTES = 3'd4;
	localparam logic [2:0] NO_BYTES   = 3'd0;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDLE    = 2'd0,
		KIND_CONTROL = 2'd1,
		KIND_DATA    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} state_t;

	// Result of the shared escape compare unit
	typedef struct packed {
		logic              need_esc;
		logic [BYTE_W-1:0] stuffed;
	} esc_t;

endpackage

`default_nettype wire

/* src/sbst_esc.sv */
// Shared escape unit: compares one payload byte against the flag and escape codes.
// Returns whether the byte must be escaped and its XORed replacement.
// Depends on sbst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbst_esc (
	input  wire logic [sbst_pkg::BYTE_W-1:0] byte_in,
	output sbst_pkg::esc_t                   esc
);
	import sbst_pkg::*;

	// Flag or escape byte goes out as escape plus XORed byte
	always_comb begin
		esc.need_esc = (byte_in == FLAG_BYTE) || (byte_in == ESCAPE_BYTE);
		esc.stuffed  = byte_in ^ ESCAPE_XOR;
	end

endmodule

`default_nettype wire

/* src/sbst_seq.sv */
// Byte sequencer: holds one symbol and issues its line bytes one per cycle unless the output stalls.
// Drives the shared escape unit and owns the output register.
// Depends on sbst_pkg and sbst_esc.
`timescale 1ns / 1ps
`default_nettype none

module sbst_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic [sbst_pkg::KIND_W-1:0] kind_in,
	input  wire logic [sbst_pkg::WORD_W-1:0] word_in,
	output logic                             idle,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sbst_pkg::BYTE_W-1:0]      out_byte,
	output logic                             out_last
);
	import sbst_pkg::*;

	state_t            state_q, state_nxt;
	logic [WORD_W-1:0] word_q;
	logic [2:0]        cnt_q;
	logic              flag_q;
	logic              esc_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	esc_t              esc;
	logic              out_free;
	logic              emit;
	logic              last_payload;
	logic              done;
	logic              shift;
	logic              set_esc;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;
	kind_t             kind;

	assign kind = kind_t'(kind_in);

	sbst_esc u_esc (
		.byte_in (word_q[WORD_W-1 -: BYTE_W]),
		.esc     (esc)
	);

	assign out_free     = !valid_q || out_ready;
	assign emit         = (state_q == ST_SEND) && out_free;
	assign last_payload = (cnt_q == 3'd1) && !flag_q;

	// Pick the next line byte
	always_comb begin
		done      = 1'b0;
		shift     = 1'b0;
		set_esc   = 1'b0;
		emit_byte = FLAG_BYTE;
		emit_last = 1'b0;
		if (emit) begin
			if (cnt_q == NO_BYTES) begin
				emit_byte = FLAG_BYTE;
				emit_last = 1'b1;
				done      = 1'b1;
			end else if (esc_q) begin
				emit_byte = esc.stuffed;
				emit_last = last_payload;
				shift     = 1'b1;
				done      = last_payload;
			end else if (esc.need_esc) begin
				emit_byte = ESCAPE_BYTE;
				set_esc   = 1'b1;
			end else begin
				emit_byte = word_q[WORD_W-1 -: BYTE_W];
				emit_last = last_payload;
				shift     = 1'b1;
				done      = last_payload;
			end
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (load) state_nxt = ST_SEND;
			end
			ST_SEND: begin
				if (done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			esc_q   <= 1'b0;
			cnt_q   <= NO_BYTES;
			flag_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load) begin
				esc_q <= 1'b0;
				case (kind)
					KIND_IDLE: begin
						cnt_q  <= NO_BYTES;
						flag_q <= 1'b1;
					end
					KIND_CONTROL: begin
						cnt_q  <= CTRL_BYTES;
						flag_q <= 1'b1;
					end
					default: begin
						cnt_q  <= DATA_BYTES;
						flag_q <= 1'b0;
					end
				endcase
			end else begin
				if (set_esc) esc_q <= 1'b1;
				else if (shift) esc_q <= 1'b0;
				if (shift) cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// Payload registers: symbol word and output byte
	always_ff @(posedge clk) begin
		if (load) begin
			if (kind == KIND_CONTROL) word_q <= {word_in[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
			else word_q <= word_in;
		end else if (shift) begin
			word_q <= {word_q[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	// Outputs
	always_comb begin
		idle      = (state_q == ST_IDLE);
		out_valid = valid_q;
		out_byte  = byte_q;
		out_last  = last_q;
	end

endmodule

`default_nettype wire

/* src/symbol_byte_stuff_transmitter_unit.sv */
// Symbol byte-stuff transmitter top level. Accepts one symbol per transfer and
// emits one to eight stuffed line bytes at one byte per cycle from the byte
// sequencer, which walks the symbol's bytes through a single shared escape
// compare unit. A symbol is taken in while the sequencer is idle and then sent
// out as its line bytes, one after another; s_tready stays low while a symbol
// is being sent and returns once its last byte is in the output register.
// Back-pressure on the master side stalls the sequencer.
// Depends on sbst_pkg and sbst_seq.
`timescale 1ns / 1ps
`default_nettype none

module symbol_byte_stuff_transmitter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] symbol_word
	input  wire logic [1:0]  s_tuser,  // [1:0] symbol_kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] line_byte
	output logic             m_tlast   // symbol_end
);
	import sbst_pkg::*;

	logic idle;
	logic load;

	// Take a new symbol only while the sequencer is idle
	assign s_tready = idle;
	assign load     = s_tvalid && idle;

	sbst_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.kind_in   (s_tuser[KIND_W-1:0]),
		.word_in   (s_tdata[WORD_W-1:0]),
		.idle      (idle),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire
